// File: src/ufc_pkg.sv
// ----------------------------------------------------------------------------
// ufc_pkg
// Shared widths, codes and store port types for the union-find engine.
// ----------------------------------------------------------------------------
package ufc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = VTX_W + 1;
    localparam int RANK_W       = 3;

    localparam logic [RANK_W-1:0] RANK_MAX     = {RANK_W{1'b1}};
    localparam logic [CNT_W-1:0]  COUNT_RESET  = CNT_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0]  COUNT_LIMIT  = CNT_W'(MAX_VERTICES);

    localparam logic CMD_EDGE   = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    typedef logic [VTX_W-1:0]  vtx_t;
    typedef logic [RANK_W-1:0] rank_t;

    // registered read result, already resolved against the valid bits
    typedef struct packed {
        vtx_t  parent;
        rank_t rank;
    } store_rd_t;

    typedef struct packed {
        logic  p_en;
        vtx_t  p_addr;
        vtx_t  p_data;
        logic  r_en;
        vtx_t  r_addr;
        rank_t r_data;
    } store_wr_t;

endpackage

// File: src/union_find_components_top.sv
// ----------------------------------------------------------------------------
// union_find_components_top
// Disjoint-set engine with path compression and union by rank.
// ----------------------------------------------------------------------------
// One item is handled at a time; s_tready is high only while the engine is
// idle. The time an edge item takes grows with da and db, the link depths of
// its two endpoints (each at most six with rank-balanced trees), and the
// rank reads are skipped when both endpoints already share a root: every parent
// lookup, compression write and rank read goes through the single registered
// read port of the link store, one access per cycle.
// An edge with an endpoint at or beyond vertex_count is dropped.
// A report item scans the first vertex_count entries (at most 64) at one per
// cycle unless m_tready holds the scan back, and ends with a one-cycle clear of
// the whole store; any roots found leave as one packet closed by m_tlast.
// ----------------------------------------------------------------------------
module union_find_components_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: vertex_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [5:0] src_vertex, [11:6] dst_vertex
    input  logic [0:0]  s_tuser,    // [0] command
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [5:0] root_vertex
    output logic        m_tlast     // last_root
);
    import ufc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_COMP  = 3'd2;
    localparam logic [2:0] S_RANKA = 3'd3;
    localparam logic [2:0] S_RANKB = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic             phase_reg, phase_next;
    vtx_t             cur_reg, cur_next;
    vtx_t             start_reg, start_next;
    vtx_t             root_reg, root_next;
    vtx_t             dst_reg, dst_next;
    vtx_t             ra_reg, ra_next;
    vtx_t             rb_reg, rb_next;
    rank_t            rank_a_reg, rank_a_next;
    vtx_t             pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0] count_reg;

    logic             m_valid_reg, m_valid_next;
    vtx_t             m_root_reg;
    logic             m_last_reg;

    vtx_t             rd_addr;
    store_rd_t        rd;
    store_wr_t        wr;
    logic             clear;

    logic             emit;
    logic             emit_last;
    logic             walk_end;
    vtx_t             walk_root;
    logic             out_free;
    logic             is_root;
    logic [CNT_W-1:0] n_active;
    logic [CNT_W-1:0] n_last;
    vtx_t             in_src;
    vtx_t             in_dst;

    ufc_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (clear),
        .rd_addr (rd_addr),
        .rd_data (rd),
        .wr      (wr)
    );

    assign in_src    = s_tdata[VTX_W-1:0];
    assign in_dst    = s_tdata[2*VTX_W-1:VTX_W];
    assign n_active  = (count_reg > COUNT_LIMIT) ? COUNT_LIMIT : count_reg;
    assign n_last    = n_active - CNT_W'(1);
    assign out_free  = !m_valid_reg || m_tready;
    assign is_root   = (rd.parent == cur_reg);
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        cur_next        = cur_reg;
        start_next      = start_reg;
        root_next       = root_reg;
        dst_next        = dst_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        rank_a_next     = rank_a_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        rd_addr         = cur_reg;
        wr              = '0;
        clear           = 1'b0;
        emit            = 1'b0;
        emit_last       = 1'b0;
        walk_end        = 1'b0;
        walk_root       = root_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == CMD_REPORT) begin
                        pend_valid_next = 1'b0;
                        cur_next        = '0;
                        rd_addr         = '0;
                        state_next      = (n_active == '0) ? S_FLUSH : S_SCAN;
                    end else if ({1'b0, in_src} < n_active && {1'b0, in_dst} < n_active) begin
                        phase_next = 1'b0;
                        cur_next   = in_src;
                        start_next = in_src;
                        dst_next   = in_dst;
                        rd_addr    = in_src;
                        state_next = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (is_root) begin
                    root_next = cur_reg;
                    if (start_reg == cur_reg) begin
                        walk_end  = 1'b1;
                        walk_root = cur_reg;
                    end else begin
                        cur_next   = start_reg;
                        rd_addr    = start_reg;
                        state_next = S_COMP;
                    end
                end else begin
                    cur_next = rd.parent;
                    rd_addr  = rd.parent;
                end
            end
            S_COMP: begin
                // point this vertex straight at the root, then follow its old link
                wr.p_en   = 1'b1;
                wr.p_addr = cur_reg;
                wr.p_data = root_reg;
                if (rd.parent == root_reg) begin
                    walk_end  = 1'b1;
                    walk_root = root_reg;
                end else begin
                    cur_next = rd.parent;
                    rd_addr  = rd.parent;
                end
            end
            S_RANKA: begin
                rank_a_next = rd.rank;
                rd_addr     = rb_reg;
                state_next  = S_RANKB;
            end
            S_RANKB: begin
                if (rank_a_reg < rd.rank) begin
                    wr.p_en   = 1'b1;
                    wr.p_addr = ra_reg;
                    wr.p_data = rb_reg;
                end else begin
                    wr.p_en   = 1'b1;
                    wr.p_addr = rb_reg;
                    wr.p_data = ra_reg;
                    if (rank_a_reg == rd.rank && rank_a_reg != RANK_MAX) begin
                        wr.r_en   = 1'b1;
                        wr.r_addr = ra_reg;
                        wr.r_data = rank_a_reg + rank_t'(1);
                    end
                end
                state_next = S_IDLE;
            end
            S_SCAN: begin
                // a root held back waits for the next one to know it is not last
                if (!(is_root && pend_valid_reg && !out_free)) begin
                    if (is_root) begin
                        emit            = pend_valid_reg;
                        pend_next       = cur_reg;
                        pend_valid_next = 1'b1;
                    end
                    if ({1'b0, cur_reg} == n_last) begin
                        state_next = S_FLUSH;
                    end else begin
                        cur_next = cur_reg + vtx_t'(1);
                        rd_addr  = cur_reg + vtx_t'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (!pend_valid_reg) begin
                    clear      = 1'b1;
                    state_next = S_IDLE;
                end else if (out_free) begin
                    emit            = 1'b1;
                    emit_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    clear           = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (walk_end) begin
            if (!phase_reg) begin
                ra_next    = walk_root;
                phase_next = 1'b1;
                cur_next   = dst_reg;
                start_next = dst_reg;
                rd_addr    = dst_reg;
                state_next = S_FIND;
            end else if (walk_root == ra_reg) begin
                state_next = S_IDLE;
            end else begin
                rb_next    = walk_root;
                rd_addr    = ra_reg;
                state_next = S_RANKA;
            end
        end
    end

    assign m_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            count_reg      <= COUNT_RESET;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg  <= phase_next;
        cur_reg    <= cur_next;
        start_reg  <= start_next;
        root_reg   <= root_next;
        dst_reg    <= dst_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        rank_a_reg <= rank_a_next;
        pend_reg   <= pend_next;
        if (emit) begin
            m_root_reg <= pend_reg;
            m_last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - VTX_W){1'b0}}, m_root_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: src/ufc_store.sv
// ----------------------------------------------------------------------------
// ufc_store
// Parent link and rank memories with one registered read port, one write
// port each, and per-entry valid bits that give identity parents and zero
// ranks after reset or a flash clear.
// ----------------------------------------------------------------------------
module ufc_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                clear,
    input  ufc_pkg::vtx_t       rd_addr,
    output ufc_pkg::store_rd_t  rd_data,
    input  ufc_pkg::store_wr_t  wr
);
    import ufc_pkg::*;

    vtx_t                    parent_mem_reg [MAX_VERTICES];
    rank_t                   rank_mem_reg   [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] pvalid_reg;
    logic [MAX_VERTICES-1:0] rvalid_reg;

    vtx_t  rd_addr_reg;
    vtx_t  rd_par_reg;
    rank_t rd_rank_reg;
    logic  rd_pv_reg;
    logic  rd_rv_reg;

    always_ff @(posedge aclk) begin
        if (wr.p_en) begin
            parent_mem_reg[wr.p_addr] <= wr.p_data;
        end
        if (wr.r_en) begin
            rank_mem_reg[wr.r_addr] <= wr.r_data;
        end
        rd_par_reg  <= parent_mem_reg[rd_addr];
        rd_rank_reg <= rank_mem_reg[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvalid_reg <= '0;
            rvalid_reg <= '0;
            rd_pv_reg  <= 1'b0;
            rd_rv_reg  <= 1'b0;
        end else begin
            rd_pv_reg <= pvalid_reg[rd_addr];
            rd_rv_reg <= rvalid_reg[rd_addr];
            if (clear) begin
                pvalid_reg <= '0;
                rvalid_reg <= '0;
            end else begin
                if (wr.p_en) begin
                    pvalid_reg[wr.p_addr] <= 1'b1;
                end
                if (wr.r_en) begin
                    rvalid_reg[wr.r_addr] <= 1'b1;
                end
            end
        end
    end

    // an entry never written reads as its own index with rank zero
    assign rd_data.parent = rd_pv_reg ? rd_par_reg : rd_addr_reg;
    assign rd_data.rank   = rd_rv_reg ? rd_rank_reg : '0;

endmodule

// File: src/ufc_checker.sv
// ----------------------------------------------------------------------------
// ufc_checker
// Port-level checks on the union-find engine, bound to the top level.
// ----------------------------------------------------------------------------
module ufc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);
    import ufc_pkg::*;

    // a stalled result holds still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // an idle engine only ever has the closing root of a run waiting
    a_idle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("input ready with a report run still open");

    // a report always occupies the engine past the accepting cycle
    a_report_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == CMD_REPORT |=> !s_tready)
        else $error("report item did not hold the engine");

    // after a root that is not last the engine stays busy or holds the closing root
    a_run_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !s_tready || (m_tvalid && m_tlast))
        else $error("input taken in the middle of a report run");

endmodule

bind union_find_components_top ufc_checker u_ufc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the union-find component engine.
// A short table of edge, report and count rows runs first. Random phases
// follow, one per vertex count and idle pattern. Every report item is checked
// root by root against a disjoint-set model held in the bench, or a typed list
// of its table row. That model uses union by rank and full path compression.
// ----------------------------------------------------------------------------
module tb_top;
    import ufc_pkg::*;

    localparam int PERIOD_NS   = 10;
    localparam int SETTLE_CYC  = 100;   // longest edge walk or report scan
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_ITEMS = 48;

    typedef enum logic [1:0] {OP_EDGE, OP_REPORT, OP_COUNT} row_op_e;

    // typed_roots >= 0: report on a fresh store, roots 0 .. typed_roots-1
    typedef struct packed {
        row_op_e op;
        int      a;
        int      b;
        int      typed_roots;
    } plan_row_t;

    typedef struct packed {
        vtx_t root;
        logic last;
    } root_entry_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;    // [5:0] src_vertex, [11:6] dst_vertex
    logic [0:0]        s_tuser = '0;    // [0] command
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;         // [5:0] root_vertex
    logic              m_tlast;

    // model of the link store
    vtx_t              link_tbl [MAX_VERTICES];
    rank_t             rank_tbl [MAX_VERTICES];
    logic [CNT_W-1:0]  vcount;
    root_entry_t       expected_roots [$];

    int idle_mode = 0;      // 0 none, 1 sender 76%, 2 receiver 76%, 3 both 7%
    int fail_count = 0;
    int stall_cycles = 0;
    int n_edges = 0;
    int n_reports = 0;
    int n_roots = 0;
    int n_counts = 0;

    plan_row_t plan [30] = '{
        '{OP_REPORT, 0, 0, 64},     // reset store, full count
        '{OP_EDGE, 0, 63, -1},
        '{OP_EDGE, 63, 0, -1},      // already joined
        '{OP_EDGE, 1, 2, -1},
        '{OP_EDGE, 3, 4, -1},
        '{OP_EDGE, 1, 3, -1},       // rank tie between two trees
        '{OP_EDGE, 4, 2, -1},       // same tree, compresses the walk
        '{OP_EDGE, 0, 0, -1},
        '{OP_EDGE, 62, 5, -1},
        '{OP_REPORT, 0, 0, -1},
        '{OP_COUNT, 1, 0, -1},
        '{OP_EDGE, 0, 1, -1},       // out of range
        '{OP_EDGE, 0, 0, -1},
        '{OP_REPORT, 0, 0, 1},
        '{OP_COUNT, 0, 0, -1},
        '{OP_EDGE, 0, 0, -1},       // every edge dropped at count zero
        '{OP_REPORT, 0, 0, 0},
        '{OP_COUNT, 127, 0, -1},    // clamps to the full store
        '{OP_EDGE, 63, 62, -1},
        '{OP_EDGE, 5, 63, -1},
        '{OP_EDGE, 42, 21, -1},
        '{OP_REPORT, 0, 0, -1},
        '{OP_COUNT, 64, 0, -1},
        '{OP_EDGE, 20, 30, -1},
        '{OP_EDGE, 40, 20, -1},
        '{OP_EDGE, 6, 40, -1},
        '{OP_COUNT, 10, 0, -1},     // count lowered, vertex 6 hangs off 20
        '{OP_REPORT, 0, 0, -1},
        '{OP_EDGE, 9, 12, -1},
        '{OP_REPORT, 0, 0, 10}
    };

    int phase_count [8] = '{64, 33, 127, 2, 64, 17, 65, 48};

    union_find_components_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #(PERIOD_NS / 2) aclk = ~aclk;

    function automatic int active_vertices();
        return (vcount > COUNT_LIMIT) ? MAX_VERTICES : int'(vcount);
    endfunction

    function automatic void clear_store();
        int v;
        for (v = 0; v < MAX_VERTICES; v++) begin
            link_tbl[v] = vtx_t'(v);
            rank_tbl[v] = '0;
        end
    endfunction

    function automatic vtx_t find_root(vtx_t v);
        vtx_t r;
        vtx_t cur;
        vtx_t nxt;
        int   i;
        r = v;
        for (i = 0; i < MAX_VERTICES && link_tbl[r] != r; i++)
            r = link_tbl[r];
        cur = v;
        for (i = 0; i < MAX_VERTICES && cur != r; i++) begin
            nxt = link_tbl[cur];
            link_tbl[cur] = r;
            cur = nxt;
        end
        return r;
    endfunction

    function automatic void join_edge(vtx_t a, vtx_t b);
        vtx_t ra;
        vtx_t rb;
        int   n;
        n = active_vertices();
        if (int'(a) >= n || int'(b) >= n)
            return;
        ra = find_root(a);
        rb = find_root(b);
        if (ra == rb)
            return;
        if (rank_tbl[ra] < rank_tbl[rb]) begin
            link_tbl[ra] = rb;
        end else if (rank_tbl[ra] > rank_tbl[rb]) begin
            link_tbl[rb] = ra;
        end else begin
            link_tbl[rb] = ra;
            if (rank_tbl[ra] != RANK_MAX)
                rank_tbl[ra] = rank_tbl[ra] + 1'b1;
        end
    endfunction

    // queues the roots below the current count unless a typed list replaces them, then clears the model
    function automatic void predict_report(bit queue_roots);
        int n;
        int v;
        int k;
        n = active_vertices();
        k = 0;
        for (v = 0; v < n; v++) begin
            if (link_tbl[v] == vtx_t'(v)) begin
                if (queue_roots)
                    expected_roots.push_back('{vtx_t'(v), 1'b0});
                k++;
            end
        end
        if (queue_roots && k > 0)
            expected_roots[$].last = 1'b1;
        clear_store();
    endfunction

    task automatic send_item(logic cmd, vtx_t a, vtx_t b, int typed_roots);
        int v;
        while ((idle_mode == 1 && $urandom_range(99) < 76) ||
               (idle_mode == 3 && $urandom_range(99) < 7)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, b, a};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (cmd == CMD_EDGE) begin
            join_edge(a, b);
            n_edges++;
        end else begin
            predict_report(typed_roots < 0);
            for (v = 0; v < typed_roots; v++)
                expected_roots.push_back('{vtx_t'(v), logic'(v == typed_roots - 1)});
            n_reports++;
        end
    endtask

    // only written with the engine idle: drained, then a settle pause
    task automatic set_count(int value);
        s_tvalid <= 1'b0;
        while (expected_roots.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[CNT_W-1:0];
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        vcount = value[CNT_W-1:0];
        n_counts++;
    endtask

    always @(posedge aclk) begin
        if (idle_mode == 2)
            m_tready <= ($urandom_range(99) >= 76);
        else if (idle_mode == 3)
            m_tready <= ($urandom_range(99) >= 7);
        else
            m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        root_entry_t exp_root;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_roots.size() == 0) begin
                $error("unexpected root item: root_vertex %0d last_root %0b",
                       m_tdata[VTX_W-1:0], m_tlast);
                fail_count++;
            end else begin
                exp_root = expected_roots.pop_front();
                n_roots++;
                if (m_tdata[VTX_W-1:0] !== exp_root.root) begin
                    $error("root_vertex: expected %0d, got %0d",
                           exp_root.root, m_tdata[VTX_W-1:0]);
                    fail_count++;
                end
                if (m_tlast !== exp_root.last) begin
                    $error("last_root: expected %0b, got %0b", exp_root.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int   r;
        int   p;
        int   i;
        int   n;
        int   lo;
        int   hi;
        vtx_t a;
        vtx_t b;
        vcount = COUNT_RESET;
        clear_store();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_mode = 3;
        for (r = 0; r < $size(plan); r++) begin
            if (plan[r].op == OP_COUNT)
                set_count(plan[r].a);
            else if (plan[r].op == OP_EDGE)
                send_item(CMD_EDGE, vtx_t'(plan[r].a), vtx_t'(plan[r].b), -1);
            else
                send_item(CMD_REPORT, vtx_t'($urandom), vtx_t'($urandom),
                          plan[r].typed_roots);
        end

        for (p = 0; p < $size(phase_count); p++) begin
            set_count(phase_count[p]);
            idle_mode = p % 4;
            n = active_vertices();
            lo = 0;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(9) == 0) begin
                    send_item(CMD_REPORT, vtx_t'($urandom), vtx_t'($urandom), -1);
                    // new cluster for the next batch of edges
                    lo = (n > 8) ? $urandom_range(n - 8) : 0;
                    // now and then hold off until the root list is out
                    if (n_reports % 4 == 0) begin
                        s_tvalid <= 1'b0;
                        while (expected_roots.size() != 0)
                            @(posedge aclk);
                    end
                end else begin
                    hi = lo + ((n > 8) ? 7 : n - 1);
                    case ($urandom_range(9))
                        0, 1: begin
                            a = vtx_t'($urandom_range(63));
                            b = vtx_t'($urandom_range(63));
                        end
                        2, 3, 4: begin
                            a = vtx_t'($urandom_range(hi, lo));
                            b = vtx_t'($urandom_range(hi, lo));
                        end
                        default: begin
                            a = vtx_t'($urandom_range(n - 1));
                            b = vtx_t'($urandom_range(n - 1));
                        end
                    endcase
                    send_item(CMD_EDGE, a, b, -1);
                end
            end
            send_item(CMD_REPORT, vtx_t'($urandom), vtx_t'($urandom), -1);
        end

        s_tvalid <= 1'b0;
        while (expected_roots.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);

        $display("tb: %0d edge items and %0d report items over %0d vertex counts",
                 n_edges, n_reports, n_counts);
        $display("tb: %0d roots compared, idle patterns on both sides", n_roots);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
src/ufc_pkg.sv
src/ufc_store.sv
src/union_find_components_top.sv
src/ufc_checker.sv
sim/tb_top.sv
